/* rtl/core/sbmc_pkg.sv */
// Package for the skeleton bone matrix chain: shared types, register indexes,
// sequencing constants and Q16.16 saturating helpers. No dependencies.
`default_nettype none
package sbmc_pkg;

    localparam logic [2:0] REG_MASK = 3'd0;
    localparam logic [2:0] REG_COS  = 3'd1;
    localparam logic [2:0] REG_SIN  = 3'd2;
    localparam logic [2:0] REG_OX   = 3'd3;
    localparam logic [2:0] REG_OY   = 3'd4;
    localparam logic [2:0] REG_OZ   = 3'd5;

    localparam logic [3:0] Q_LAST = 4'd8;   // nine quaternion products
    localparam logic [3:0] E_LAST = 4'd11;  // twelve world matrix elements
    localparam logic [1:0] K_LAST = 2'd2;   // three terms per element

    localparam logic signed [31:0] ONE_Q = 32'sd65536;

    typedef struct packed {
        logic [7:0]         bone_index;
        logic signed [8:0]  parent_index;
        logic [31:0]        bone_flags;
        logic signed [17:0] quat_x;
        logic signed [17:0] quat_y;
        logic signed [17:0] quat_z;
        logic signed [17:0] quat_w;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_bone;

    typedef struct packed {
        logic [31:0]        mask;
        logic signed [17:0] cos_v;
        logic signed [17:0] sin_v;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
    } t_cfg;

    typedef struct packed {
        logic [7:0]         out_bone;
        logic [1:0]         row_number;
        logic signed [31:0] col_0;
        logic signed [31:0] col_1;
        logic signed [31:0] col_2;
        logic signed [31:0] col_3;
        logic               last_row;
    } t_row;

    typedef struct packed {
        logic       accept;
        logic       q_issue;
        logic [3:0] q_idx;
        logic       load_local;
        logic       c_issue;
        logic [3:0] c_e;
        logic [1:0] c_k;
        logic       write;
        logic [1:0] row;
    } t_cmd;

    typedef struct packed {
        logic mask_hit;
    } t_stat;

    function automatic logic signed [31:0] f_sat(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Diagonal element: one minus twice the saturated sum.
    function automatic logic signed [31:0] f_diag(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [31:0] t;
        logic signed [31:0] u;
        t = f_sat(64'(a) + 64'(b));
        u = f_sat(64'(t) <<< 1);
        return f_sat(64'(ONE_Q) - 64'(u));
    endfunction

    // Off-diagonal element: twice the saturated sum or difference.
    function automatic logic signed [31:0] f_off(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input logic               neg);
        logic signed [31:0] t;
        t = neg ? f_sat(64'(a) - 64'(b)) : f_sat(64'(a) + 64'(b));
        return f_sat(64'(t) <<< 1);
    endfunction

endpackage
`default_nettype wire

/* rtl/core/sbmc_ifs.sv */
// Handshake interfaces for the bone input channel and the matrix row output.
// Does not depend on sbmc_pkg: the field widths are written here.
`default_nettype none
interface sbmc_bone_if;
    logic               valid;
    logic               ready;
    logic [7:0]         bone_index;
    logic signed [8:0]  parent_index;
    logic [31:0]        bone_flags;
    logic signed [17:0] quat_x;
    logic signed [17:0] quat_y;
    logic signed [17:0] quat_z;
    logic signed [17:0] quat_w;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    modport source (output valid, bone_index, parent_index, bone_flags, quat_x, quat_y,
                    quat_z, quat_w, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, bone_index, parent_index, bone_flags, quat_x, quat_y,
                  quat_z, quat_w, pos_x, pos_y, pos_z, output ready);
endinterface

interface sbmc_row_if;
    logic               valid;
    logic               ready;
    logic [7:0]         out_bone;
    logic [1:0]         row_number;
    logic signed [31:0] col_0;
    logic signed [31:0] col_1;
    logic signed [31:0] col_2;
    logic signed [31:0] col_3;
    logic               last_row;
    modport source (output valid, out_bone, row_number, col_0, col_1, col_2, col_3,
                    last_row, input ready);
    modport sink (input valid, out_bone, row_number, col_0, col_1, col_2, col_3,
                  last_row, output ready);
endinterface
`default_nettype wire

/* rtl/core/skeleton_bone_matrix_chain_top.sv */
// Top level of the skeleton bone matrix chain: configuration registers on the
// APB-style port, and the sequencer and datapath. Uses sbmc_pkg, sbmc_ifs, sbmc_ctrl, sbmc_dp.
//
//  Channel   Direction  Handshake             Moves per transfer
//  i_bone    in         valid / ready         one bone: indices, flags, quaternion, position
//  o_row     out        valid / ready         one world matrix row of a bone
//  APB       in         psel/penable/pready   one 32-bit register write or read
//
// A bone whose flags meet the mask sends nine quaternion and thirty-six matrix products in
// turn through the one shared 32x32 multiplier, with a drain state after each burst and a
// state between the bursts to form the local matrix; then its three rows are offered. Each
// row waits for the sink; the next bone is taken only after the third row, and a masked
// bone is taken while the sequencer stays idle and sends no rows. Reset restores the
// defaults and marks every stored matrix as zero.
`default_nettype none
module skeleton_bone_matrix_chain_top #(
    parameter int MAX_BONES = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sbmc_bone_if.sink        i_bone,
    sbmc_row_if.source       o_row,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    sbmc_pkg::t_cfg  r_cfg;
    sbmc_pkg::t_bone bone;
    sbmc_pkg::t_cmd  cmd;
    sbmc_pkg::t_stat stat;
    sbmc_pkg::t_row  row;
    logic            out_valid;
    logic            in_ready;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    // Configuration registers; a write beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mask  <= 32'hffffffff;
            r_cfg.cos_v <= 18'sd65536;
            r_cfg.sin_v <= 18'sd0;
            r_cfg.ox    <= 32'sd0;
            r_cfg.oy    <= 32'sd0;
            r_cfg.oz    <= 32'sd0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                sbmc_pkg::REG_MASK: r_cfg.mask  <= pwdata;
                sbmc_pkg::REG_COS:  r_cfg.cos_v <= pwdata[17:0];
                sbmc_pkg::REG_SIN:  r_cfg.sin_v <= pwdata[17:0];
                sbmc_pkg::REG_OX:   r_cfg.ox    <= pwdata;
                sbmc_pkg::REG_OY:   r_cfg.oy    <= pwdata;
                sbmc_pkg::REG_OZ:   r_cfg.oz    <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            sbmc_pkg::REG_MASK: prdata = r_cfg.mask;
            sbmc_pkg::REG_COS:  prdata = 32'(r_cfg.cos_v);
            sbmc_pkg::REG_SIN:  prdata = 32'(r_cfg.sin_v);
            sbmc_pkg::REG_OX:   prdata = r_cfg.ox;
            sbmc_pkg::REG_OY:   prdata = r_cfg.oy;
            sbmc_pkg::REG_OZ:   prdata = r_cfg.oz;
            default:            prdata = '0;
        endcase
    end

    always_comb begin
        bone.bone_index   = i_bone.bone_index;
        bone.parent_index = i_bone.parent_index;
        bone.bone_flags   = i_bone.bone_flags;
        bone.quat_x       = i_bone.quat_x;
        bone.quat_y       = i_bone.quat_y;
        bone.quat_z       = i_bone.quat_z;
        bone.quat_w       = i_bone.quat_w;
        bone.pos_x        = i_bone.pos_x;
        bone.pos_y        = i_bone.pos_y;
        bone.pos_z        = i_bone.pos_z;
    end

    sbmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_bone.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_row.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sbmc_dp #(
        .MAX_BONES (MAX_BONES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bone  (bone),
        .i_cfg   (r_cfg),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_row   (row)
    );

    assign i_bone.ready     = in_ready;
    assign o_row.valid      = out_valid;
    assign o_row.out_bone   = row.out_bone;
    assign o_row.row_number = row.row_number;
    assign o_row.col_0      = row.col_0;
    assign o_row.col_1      = row.col_1;
    assign o_row.col_2      = row.col_2;
    assign o_row.col_3      = row.col_3;
    assign o_row.last_row   = row.last_row;
endmodule
`default_nettype wire

/* rtl/core/sbmc_ctrl.sv */
// Sequencer for the bone transform: steps the shared multiplier through the
// quaternion and matrix products and paces the three row transfers. Uses sbmc_pkg.
`default_nettype none
module sbmc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire sbmc_pkg::t_stat i_stat,
    output sbmc_pkg::t_cmd      o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_QMUL  = 4'd1;
    localparam logic [3:0] S_QDRN  = 4'd2;
    localparam logic [3:0] S_LOCAL = 4'd3;
    localparam logic [3:0] S_CMUL  = 4'd4;
    localparam logic [3:0] S_CDRN  = 4'd5;
    localparam logic [3:0] S_OUT0  = 4'd6;
    localparam logic [3:0] S_OUT1  = 4'd7;
    localparam logic [3:0] S_OUT2  = 4'd8;

    logic [3:0] r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [1:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_k         = r_k;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_cnt = '0;
                    if (i_stat.mask_hit) begin
                        n_state = S_QMUL;
                    end
                end
            end
            S_QMUL: begin
                o_cmd.q_issue = 1'b1;
                o_cmd.q_idx   = r_cnt;
                if (r_cnt == sbmc_pkg::Q_LAST) begin
                    n_state = S_QDRN;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            S_QDRN: begin
                n_state = S_LOCAL;
            end
            S_LOCAL: begin
                o_cmd.load_local = 1'b1;
                n_cnt   = '0;
                n_k     = '0;
                n_state = S_CMUL;
            end
            S_CMUL: begin
                o_cmd.c_issue = 1'b1;
                o_cmd.c_e     = r_cnt;
                o_cmd.c_k     = r_k;
                if (r_k == sbmc_pkg::K_LAST) begin
                    n_k = '0;
                    if (r_cnt == sbmc_pkg::E_LAST) begin
                        n_state = S_CDRN;
                    end else begin
                        n_cnt = r_cnt + 4'd1;
                    end
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_CDRN: begin
                n_state = S_OUT0;
            end
            S_OUT0: begin
                o_out_valid = 1'b1;
                o_cmd.write = 1'b1;
                o_cmd.row   = 2'd0;
                if (i_out_ready) begin
                    n_state = S_OUT1;
                end
            end
            S_OUT1: begin
                o_out_valid = 1'b1;
                o_cmd.row   = 2'd1;
                if (i_out_ready) begin
                    n_state = S_OUT2;
                end
            end
            S_OUT2: begin
                o_out_valid = 1'b1;
                o_cmd.row   = 2'd2;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while rows are pending");
    a_hit_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_stat.mask_hit) |=> (r_state == S_QMUL && r_cnt == 4'd0))
        else $error("accepted bone did not start the product sequence");
    a_last_row_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT2 && i_out_ready) |=> o_in_ready)
        else $error("block did not return to idle after the third row");
endmodule
`default_nettype wire

/* rtl/core/sbmc_dp.sv */
// Datapath for the bone transform: shared 32x32 multiplier, quaternion and
// local matrix registers, world accumulator and the matrix store. Uses sbmc_pkg.
`default_nettype none
module sbmc_dp #(
    parameter int MAX_BONES = 256
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sbmc_pkg::t_bone i_bone,
    input  wire sbmc_pkg::t_cfg  i_cfg,
    input  wire sbmc_pkg::t_cmd  i_cmd,
    output sbmc_pkg::t_stat      o_stat,
    output sbmc_pkg::t_row       o_row
);
    localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    typedef logic [AW-1:0] t_slot_tab [256];

    function automatic t_slot_tab f_mk_tab();
        t_slot_tab t;
        for (int i = 0; i < 256; i++) begin
            t[i] = AW'(i % MAX_BONES);
        end
        return t;
    endfunction
    localparam t_slot_tab SLOT_TAB = f_mk_tab();

    logic [383:0]       r_mem [MAX_BONES];
    logic [MAX_BONES-1:0] r_vld;
    logic [383:0]       r_rd;
    logic               r_pvld;
    logic               r_root;
    logic [AW-1:0]      r_slot;
    logic [7:0]         r_bone;
    logic signed [17:0] r_qx, r_qy, r_qz, r_qw;
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [31:0] r_q [9];
    logic signed [31:0] r_l [12];
    logic signed [31:0] r_w [12];
    logic signed [63:0] r_prod;
    logic               r_tv, r_tq;
    logic [3:0]         r_te;
    logic [1:0]         r_tk;

    logic signed [31:0] p [12];
    logic signed [31:0] mul_a, mul_b;
    logic signed [31:0] prod_sat;
    logic signed [31:0] acc_old, acc_v;
    logic signed [47:0] prod_q;

    assign o_stat.mask_hit = |(i_bone.bone_flags & i_cfg.mask);

    // Parent matrix: root transform, stored matrix, or zero if never written.
    always_comb begin
        for (int k = 0; k < 12; k++) begin
            p[k] = r_pvld ? r_rd[32*k +: 32] : 32'sd0;
        end
        if (r_root) begin
            p[0]  = 32'(i_cfg.cos_v);
            p[1]  = -32'(i_cfg.sin_v);
            p[2]  = 32'sd0;
            p[3]  = i_cfg.ox;
            p[4]  = 32'(i_cfg.sin_v);
            p[5]  = 32'(i_cfg.cos_v);
            p[6]  = 32'sd0;
            p[7]  = i_cfg.oy;
            p[8]  = 32'sd0;
            p[9]  = 32'sd0;
            p[10] = sbmc_pkg::ONE_Q;
            p[11] = i_cfg.oz;
        end
    end

    always_comb begin
        mul_a = 32'(r_qx);
        mul_b = 32'(r_qx);
        if (i_cmd.c_issue) begin
            mul_a = p[{i_cmd.c_e[3:2], i_cmd.c_k}];
            mul_b = r_l[{i_cmd.c_k, i_cmd.c_e[1:0]}];
        end else begin
            case (i_cmd.q_idx)
                4'd0: begin mul_a = 32'(r_qx); mul_b = 32'(r_qx); end
                4'd1: begin mul_a = 32'(r_qy); mul_b = 32'(r_qy); end
                4'd2: begin mul_a = 32'(r_qz); mul_b = 32'(r_qz); end
                4'd3: begin mul_a = 32'(r_qx); mul_b = 32'(r_qy); end
                4'd4: begin mul_a = 32'(r_qx); mul_b = 32'(r_qz); end
                4'd5: begin mul_a = 32'(r_qy); mul_b = 32'(r_qz); end
                4'd6: begin mul_a = 32'(r_qw); mul_b = 32'(r_qx); end
                4'd7: begin mul_a = 32'(r_qw); mul_b = 32'(r_qy); end
                4'd8: begin mul_a = 32'(r_qw); mul_b = 32'(r_qz); end
                default: begin mul_a = 32'(r_qx); mul_b = 32'(r_qx); end
            endcase
        end
    end

    // Floor of product over 65536 is an arithmetic shift.
    assign prod_q   = r_prod[63:16];
    assign prod_sat = sbmc_pkg::f_sat(64'(prod_q));

    always_comb begin
        acc_old = (r_tk == 2'd0) ? 32'sd0 : r_w[r_te];
        acc_v   = sbmc_pkg::f_sat(64'(acc_old) + 64'(prod_q));
        if (r_tk == sbmc_pkg::K_LAST && r_te[1:0] == 2'd3) begin
            acc_v = sbmc_pkg::f_sat(64'(acc_v) + 64'(p[{r_te[3:2], 2'd3}]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_tv  <= 1'b0;
        end else begin
            r_tv <= i_cmd.q_issue | i_cmd.c_issue;
            if (i_cmd.write) begin
                r_vld[r_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd   <= r_mem[SLOT_TAB[i_bone.parent_index[7:0]]];
            r_pvld <= r_vld[SLOT_TAB[i_bone.parent_index[7:0]]];
            r_root <= i_bone.parent_index[8];
            r_slot <= SLOT_TAB[i_bone.bone_index];
            r_bone <= i_bone.bone_index;
            r_qx   <= i_bone.quat_x;
            r_qy   <= i_bone.quat_y;
            r_qz   <= i_bone.quat_z;
            r_qw   <= i_bone.quat_w;
            r_px   <= i_bone.pos_x;
            r_py   <= i_bone.pos_y;
            r_pz   <= i_bone.pos_z;
        end
        if (i_cmd.write) begin
            for (int k = 0; k < 12; k++) begin
                r_mem[r_slot][32*k +: 32] <= r_w[k];
            end
        end
        r_prod <= mul_a * mul_b;
        r_tq   <= i_cmd.q_issue;
        r_te   <= i_cmd.c_issue ? i_cmd.c_e : i_cmd.q_idx;
        r_tk   <= i_cmd.c_k;
        if (r_tv) begin
            if (r_tq) begin
                r_q[r_te] <= prod_sat;
            end else begin
                r_w[r_te] <= acc_v;
            end
        end
        if (i_cmd.load_local) begin
            // Products in order xx yy zz xy xz yz wx wy wz.
            r_l[0]  <= sbmc_pkg::f_diag(r_q[1], r_q[2]);
            r_l[1]  <= sbmc_pkg::f_off(r_q[3], r_q[8], 1'b1);
            r_l[2]  <= sbmc_pkg::f_off(r_q[4], r_q[7], 1'b0);
            r_l[3]  <= r_px;
            r_l[4]  <= sbmc_pkg::f_off(r_q[3], r_q[8], 1'b0);
            r_l[5]  <= sbmc_pkg::f_diag(r_q[0], r_q[2]);
            r_l[6]  <= sbmc_pkg::f_off(r_q[5], r_q[6], 1'b1);
            r_l[7]  <= r_py;
            r_l[8]  <= sbmc_pkg::f_off(r_q[4], r_q[7], 1'b1);
            r_l[9]  <= sbmc_pkg::f_off(r_q[5], r_q[6], 1'b0);
            r_l[10] <= sbmc_pkg::f_diag(r_q[0], r_q[1]);
            r_l[11] <= r_pz;
        end
    end

    always_comb begin
        o_row.out_bone   = r_bone;
        o_row.row_number = i_cmd.row;
        o_row.col_0      = r_w[{i_cmd.row, 2'd0}];
        o_row.col_1      = r_w[{i_cmd.row, 2'd1}];
        o_row.col_2      = r_w[{i_cmd.row, 2'd2}];
        o_row.col_3      = r_w[{i_cmd.row, 2'd3}];
        o_row.last_row   = (i_cmd.row == 2'd2);
    end
endmodule
`default_nettype wire
